// ===== rtl/assert_macros.svh =====
// assertion macros shared by the modular division block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication checked on every clock edge out of reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked out of reset
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mdee_pkg.sv =====
// shared types, constants and command/status structs for the modular division block
// no dependencies
package mdee_pkg;

  localparam int unsigned WIDTH_DEF   = 31;
  localparam int unsigned FIELD_W     = 31;
  localparam logic [FIELD_W-1:0] MODULUS_RST = 31'h7fff_ffff;

  localparam logic [0:0] STATUS_OK  = 1'b0;
  localparam logic [0:0] STATUS_ERR = 1'b1;

  localparam logic [0:0] REG_MODULUS = 1'b0;

  typedef struct packed {
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic               status;
  } out_item_t;

  // datapath operation select
  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_DIV    = 3'd1,
    OP_MULQ   = 3'd2,
    OP_UPDATE = 3'd3,
    OP_MULA   = 3'd4,
    OP_NONE   = 3'd5
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic bad_args;
    logic r_zero;
    logic gcd_one;
  } dp_stat_t;

endpackage

// ===== rtl/mdee_datapath.sv =====
// datapath: remainder/coefficient registers, a shared serial divider and mul-mod unit
// depends on mdee_pkg
module mdee_datapath #(
  parameter int unsigned WIDTH = mdee_pkg::WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mdee_pkg::dp_cmd_t   cmd,
  input  logic [WIDTH-1:0]    modulus,
  input  logic [WIDTH-1:0]    a_in,
  input  logic [WIDTH-1:0]    b_in,
  output mdee_pkg::dp_stat_t  stat,
  output logic [WIDTH-1:0]    result
);
  import mdee_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] p_r, a_r;
  logic [WIDTH-1:0] rp_r, rc_r, yp_r, yc_r;
  logic [WIDTH-1:0] q_r, t_r, rn_r;

  // serial unit state: shared by restoring divider and shift-add mul-mod
  logic             busy_r, busy_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] sa_r, sa_nxt;   // divider: quotient shift; mul: multiplier y
  logic [WIDTH:0]   sb_r, sb_nxt;   // divider: partial remainder; mul: x
  logic [WIDTH:0]   acc_r, acc_nxt; // mul accumulator
  logic             mode_div_r, mode_div_nxt;

  logic [WIDTH:0]   rem_sh, p_ext, acc_add, x_dbl;
  logic [WIDTH-1:0] y_sub;

  assign p_ext   = {1'b0, p_r};
  assign rem_sh  = {sb_r[WIDTH-1:0], sa_r[WIDTH-1]};
  assign acc_add = acc_r + {1'b0, sb_r[WIDTH-1:0]};
  assign x_dbl   = {sb_r[WIDTH-1:0], 1'b0};
  assign y_sub   = (yp_r >= t_r) ? (yp_r - t_r) : (yp_r + (p_r - t_r));

  // serial unit step
  always_comb begin
    busy_nxt     = busy_r;
    cnt_nxt      = cnt_r;
    sa_nxt       = sa_r;
    sb_nxt       = sb_r;
    acc_nxt      = acc_r;
    mode_div_nxt = mode_div_r;
    if (cmd.start && cmd.op == OP_DIV) begin
      busy_nxt = 1'b1; mode_div_nxt = 1'b1;
      cnt_nxt = CW'(WIDTH); sa_nxt = rp_r; sb_nxt = '0;
    end else if (cmd.start && (cmd.op == OP_MULQ || cmd.op == OP_MULA)) begin
      busy_nxt = 1'b1; mode_div_nxt = 1'b0;
      cnt_nxt = CW'(WIDTH); acc_nxt = '0;
      if (cmd.op == OP_MULQ) begin
        sa_nxt = q_r;
        sb_nxt = {1'b0, yc_r};
      end else begin
        sa_nxt = a_r;
        sb_nxt = {1'b0, yp_r};
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
      if (mode_div_r) begin
        if (rem_sh >= {1'b0, rc_r}) begin
          sb_nxt = rem_sh - {1'b0, rc_r};
          sa_nxt = {sa_r[WIDTH-2:0], 1'b1};
        end else begin
          sb_nxt = rem_sh;
          sa_nxt = {sa_r[WIDTH-2:0], 1'b0};
        end
      end else begin
        if (sa_r[0]) acc_nxt = (acc_add >= p_ext) ? acc_add - p_ext : acc_add;
        sb_nxt = (x_dbl >= p_ext) ? x_dbl - p_ext : x_dbl;
        sa_nxt = sa_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    acc_r      <= acc_nxt;
    mode_div_r <= mode_div_nxt;
  end

  // euclid registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      unique case (cmd.op)
        OP_LOAD: begin
          p_r  <= modulus;
          rp_r <= modulus;
          rc_r <= b_in;
          yp_r <= '0;
          yc_r <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
        OP_UPDATE: begin
          rp_r <= rc_r;
          rc_r <= rn_r;
          yp_r <= yc_r;
          yc_r <= y_sub;
        end
        default: ;
      endcase
    end
    // divider done: keep quotient and remainder, the mul-mod reuses the shift registers
    if (busy_r && mode_div_r && cnt_r == CW'(1)) begin
      q_r  <= sa_nxt;
      rn_r <= sb_nxt[WIDTH-1:0];
    end
    if (busy_r && !mode_div_r && cnt_r == CW'(1)) t_r <= acc_nxt[WIDTH-1:0];
    if (cmd.start && cmd.op == OP_LOAD) a_r <= a_in;
  end

  assign stat.busy     = busy_r;
  assign stat.bad_args = (p_r == '0) || (rc_r == '0);
  assign stat.r_zero   = (rc_r == '0);
  assign stat.gcd_one  = (rp_r == WIDTH'(1));
  assign result        = t_r;

endmodule

// ===== rtl/mdee_ctrl.sv =====
// controller fsm sequencing euclid steps and handshakes
// depends on mdee_pkg and assert_macros.svh
module mdee_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic               out_use_res,
  output mdee_pkg::dp_cmd_t  cmd,
  input  mdee_pkg::dp_stat_t stat
);
  import mdee_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHK   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_MULQ  = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_MULA  = 8'b0010_0000,
    S_WAIT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;
  logic   status_r, status_nxt, use_r, use_nxt;

  // next state
  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    status_nxt   = status_r;
    use_nxt      = use_r;
    cmd.start    = 1'b0;
    cmd.op       = OP_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.start = 1'b1; cmd.op = OP_LOAD; state_nxt = S_CHK;
      end
      S_CHK: if (stat.bad_args) begin
        status_nxt = STATUS_ERR; use_nxt = 1'b0; state_nxt = S_OUT;
      end else begin
        state_nxt = S_DIV; launched_nxt = 1'b0;
      end
      S_DIV, S_MULQ, S_MULA: begin
        if (!launched_r) begin
          cmd.start = 1'b1;
          cmd.op = (state_r == S_DIV) ? OP_DIV : (state_r == S_MULQ) ? OP_MULQ : OP_MULA;
          launched_nxt = 1'b1;
        end else if (!stat.busy) begin
          launched_nxt = 1'b0;
          if (state_r == S_DIV) state_nxt = S_MULQ;
          else if (state_r == S_MULQ) state_nxt = S_UPD;
          else begin
            status_nxt = STATUS_OK; use_nxt = 1'b1; state_nxt = S_OUT;
          end
        end
      end
      S_UPD: begin
        cmd.start = 1'b1; cmd.op = OP_UPDATE; state_nxt = S_WAIT;
      end
      S_WAIT: if (!stat.r_zero) begin
        state_nxt = S_DIV;
      end else if (stat.gcd_one) begin
        state_nxt = S_MULA;
      end else begin
        status_nxt = STATUS_ERR; use_nxt = 1'b0; state_nxt = S_OUT;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
      status_r   <= STATUS_OK;
      use_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
      status_r   <= status_nxt;
      use_r      <= use_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign out_status  = status_r;
  assign out_use_res = use_r;

  `ASSERT_CLK(a_onehot, $onehot(state_r))
  `ASSERT_IMP(a_no_cmd_busy, cmd.start && (cmd.op == OP_DIV || cmd.op == OP_MULQ), !stat.busy)
  `ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status))

endmodule

// ===== rtl/modular_division_ext_euclid.sv =====
// top level of the modular division block: apb register, controller and datapath
// depends on mdee_pkg, mdee_ctrl, mdee_datapath
// Each item computes dividend * divisor^-1 mod modulus by the extended Euclidean
// algorithm; one item is worked on at a time. Each Euclid step runs a serial
// division and a serial mul-mod, each launched and then awaited until done, plus
// an update state and a test state. The time an item takes grows with the number
// of Euclid steps, plus any output stall (about 45 steps at worst for 31-bit
// operands); the shared serial divider and mul-mod unit sets it. Status 1 with
// quotient 0 flags a zero divisor, a zero modulus or gcd not 1.
module modular_division_ext_euclid #(
  parameter int unsigned WIDTH = mdee_pkg::WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mdee_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mdee_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mdee_pkg::*;

  logic [WIDTH-1:0] modulus_r;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [WIDTH-1:0] result;
  logic             st, use_res;

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) modulus_r <= WIDTH'(MODULUS_RST);
    else if (psel && penable && pwrite && paddr[1:0] == {REG_MODULUS, 1'b0})
      modulus_r <= WIDTH'(pwdata);
  end
  assign pready = 1'b1;
  assign prdata = 32'(modulus_r);

  mdee_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_status(st), .out_use_res(use_res), .cmd, .stat
  );

  mdee_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .modulus(modulus_r),
    .a_in(WIDTH'(in_data.dividend)), .b_in(WIDTH'(in_data.divisor)),
    .stat, .result
  );

  assign out_data.status   = st;
  assign out_data.quotient = use_res ? FIELD_W'(result) : '0;

endmodule
